// ===== hw/rtl/rcnq_pkg.sv =====
// Shared widths and the search stage record for the RGB length clamp and quantizer.
package rcnq_pkg;

	localparam int CW  = 16;
	localparam int OW  = 8;
	localparam int SQW = 2 * CW;
	localparam int SW  = SQW + 2;
	localparam int NW  = CW + OW;
	localparam int N2W = 2 * NW;
	localparam int PW  = N2W;
	localparam int QW  = SW + OW;
	localparam int TW  = N2W + 4;
	localparam int NCOMP = 3;

	localparam logic [OW-1:0] FULL_SCALE = 8'd255;

	typedef struct packed {
		logic                            scaled;
		logic [NCOMP-1:0][OW-1:0]        plain;
		logic [SW-1:0]                   sumsq;
		logic [NCOMP-1:0][N2W-1:0]       num2;
		logic [NCOMP-1:0][OW-1:0]        k;
		logic [NCOMP-1:0][PW-1:0]        p;
		logic [NCOMP-1:0][QW-1:0]        q;
	} srch_t;

endpackage

// ===== hw/rtl/rgb_clamp_normalize_quantize.sv =====
// Top level: clamps an RGB vector to unit length and quantizes each component to 8 bits.
// Throughput: one transaction per cycle; busy stays low, as the 12-stage pipeline never stalls.
// The pipeline is made of 3 front stages, 8 one-bit search stages and the output register.
// Reset (arst_n low) clears all stage valid bits and done; no transaction survives it.
module rgb_clamp_normalize_quantize import rcnq_pkg::*; #(
	parameter int FRAC_BITS = 12
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  logic [CW-1:0] red_in,
	input  logic [CW-1:0] green_in,
	input  logic [CW-1:0] blue_in,
	output logic          done,
	output logic [OW-1:0] red_out,
	output logic [OW-1:0] green_out,
	output logic [OW-1:0] blue_out,
	output logic          was_scaled
);

	localparam int NSTEP   = OW;
	localparam int LATENCY = 3 + NSTEP + 1;

	logic                     vld_st [NSTEP+1];
	srch_t                    srch_st [NSTEP+1];
	logic                     done_q;
	logic [NCOMP-1:0][OW-1:0] res_q;
	logic                     scaled_q;

	assign busy = 1'b0;

	rcnq_front #(
		.FRAC_BITS(FRAC_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_i   (start),
		.red_in  (red_in),
		.green_in(green_in),
		.blue_in (blue_in),
		.vld_o   (vld_st[0]),
		.srch_o  (srch_st[0])
	);

	for (genvar g = 0; g < NSTEP; g++) begin : g_step
		rcnq_root_step #(
			.BIT_POS(NSTEP - 1 - g)
		) u_step (
			.clk   (clk),
			.arst_n(arst_n),
			.vld_i (vld_st[g]),
			.srch_i(srch_st[g]),
			.vld_o (vld_st[g+1]),
			.srch_o(srch_st[g+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_st[NSTEP];
		end
	end

	always_ff @(posedge clk) begin
		res_q    <= srch_st[NSTEP].scaled ? srch_st[NSTEP].k : srch_st[NSTEP].plain;
		scaled_q <= srch_st[NSTEP].scaled;
	end

	assign done       = done_q;
	assign red_out    = res_q[0];
	assign green_out  = res_q[1];
	assign blue_out   = res_q[2];
	assign was_scaled = scaled_q;

	a_issue_done: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LATENCY done)
		else $error("accepted transaction produced no result");
	a_done_issue: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LATENCY))
		else $error("result without a matching transaction");
	a_scaled_floor: assert property (@(posedge clk) disable iff (!arst_n)
		(done && was_scaled) |->
		(red_out >= 8'd147 || green_out >= 8'd147 || blue_out >= 8'd147))
		else $error("normalized vector too short");

endmodule

// ===== hw/rtl/rcnq_front.sv =====
// Front stages: squares, squared length, threshold, unscaled output and squared numerators.
module rcnq_front import rcnq_pkg::*; #(
	parameter int FRAC_BITS = 12
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          vld_i,
	input  logic [CW-1:0] red_in,
	input  logic [CW-1:0] green_in,
	input  logic [CW-1:0] blue_in,
	output logic          vld_o,
	output srch_t         srch_o
);

	localparam logic [SW-1:0] ONE = SW'(1) << (2 * FRAC_BITS);

	logic [NCOMP-1:0][CW-1:0]  c_in;
	logic [NCOMP-1:0][CW-1:0]  c_s1;
	logic [NCOMP-1:0][SQW-1:0] sq_s1;
	logic [NCOMP-1:0][NW-1:0]  num_c;
	logic [NCOMP-1:0][NW-1:0]  pv_c;
	logic [NCOMP-1:0][OW-1:0]  plain_c;
	logic [SW-1:0]             sum_c;
	logic [NCOMP-1:0][NW-1:0]  num_s2;
	logic [NCOMP-1:0][OW-1:0]  plain_s2;
	logic [SW-1:0]             sumsq_s2;
	logic                      scaled_s2;
	logic [NCOMP-1:0][N2W-1:0] num2_s3;
	logic [NCOMP-1:0][OW-1:0]  plain_s3;
	logic [SW-1:0]             sumsq_s3;
	logic                      scaled_s3;
	logic                      vld_s1;
	logic                      vld_s2;
	logic                      vld_s3;

	assign c_in = {blue_in, green_in, red_in};

	always_comb begin
		sum_c = SW'(sq_s1[0]) + SW'(sq_s1[1]) + SW'(sq_s1[2]);
		for (int i = 0; i < NCOMP; i++) begin
			num_c[i] = (NW'(c_s1[i]) << OW) - NW'(c_s1[i]);
			pv_c[i]  = num_c[i] >> FRAC_BITS;
			plain_c[i] = (pv_c[i] > NW'(FULL_SCALE)) ? FULL_SCALE : pv_c[i][OW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		c_s1 <= c_in;
		for (int i = 0; i < NCOMP; i++) begin
			sq_s1[i]   <= SQW'(c_in[i]) * SQW'(c_in[i]);
			num2_s3[i] <= N2W'(num_s2[i]) * N2W'(num_s2[i]);
		end
		num_s2    <= num_c;
		plain_s2  <= plain_c;
		sumsq_s2  <= sum_c;
		scaled_s2 <= sum_c > ONE;
		plain_s3  <= plain_s2;
		sumsq_s3  <= sumsq_s2;
		scaled_s3 <= scaled_s2;
	end

	assign vld_o = vld_s3;

	always_comb begin
		srch_o.scaled = scaled_s3;
		srch_o.plain  = plain_s3;
		srch_o.sumsq  = sumsq_s3;
		srch_o.num2   = num2_s3;
		srch_o.k      = '0;
		srch_o.p      = '0;
		srch_o.q      = '0;
	end

endmodule

// ===== hw/rtl/rcnq_root_step.sv =====
// One bit of the normalized output search, for all three components, as one register stage.
module rcnq_root_step import rcnq_pkg::*; #(
	parameter int BIT_POS = 7
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  vld_i,
	input  srch_t srch_i,
	output logic  vld_o,
	output srch_t srch_o
);

	logic [NCOMP-1:0][TW-1:0] tp_c;
	logic [NCOMP-1:0]         take_c;
	srch_t                    nxt_c;
	logic                     vld_s1;
	srch_t                    srch_s1;

	always_comb begin
		nxt_c = srch_i;
		for (int i = 0; i < NCOMP; i++) begin
			tp_c[i] = TW'(srch_i.p[i]) + (TW'(srch_i.q[i]) << (BIT_POS + 1))
			        + (TW'(srch_i.sumsq) << (2 * BIT_POS));
			take_c[i] = tp_c[i] <= TW'(srch_i.num2[i]);
			if (take_c[i]) begin
				nxt_c.k[i] = srch_i.k[i] | (OW'(1) << BIT_POS);
				nxt_c.p[i] = tp_c[i][PW-1:0];
				nxt_c.q[i] = srch_i.q[i] + (QW'(srch_i.sumsq) << BIT_POS);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		srch_s1 <= nxt_c;
	end

	assign vld_o  = vld_s1;
	assign srch_o = srch_s1;

	a_red_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> srch_s1.p[0] <= srch_s1.num2[0])
		else $error("red partial product above bound");
	a_green_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> srch_s1.p[1] <= srch_s1.num2[1])
		else $error("green partial product above bound");
	a_blue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> srch_s1.p[2] <= srch_s1.num2[2])
		else $error("blue partial product above bound");

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the RGB length clamp and 8-bit quantizer.
module testbench import rcnq_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC_BITS = 12;
	localparam int LATENCY   = 12;

	typedef struct {
		bit             drain;
		int unsigned    idle_pct;
		logic [CW-1:0]  red;
		logic [CW-1:0]  green;
		logic [CW-1:0]  blue;
	} pixel_req_t;

	typedef struct {
		logic [NCOMP-1:0][OW-1:0] comp;
		logic                     scaled;
	} pixel_out_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          start = 1'b0;
	logic          busy;
	logic [CW-1:0] red_in = '0;
	logic [CW-1:0] green_in = '0;
	logic [CW-1:0] blue_in = '0;
	logic          done;
	logic [OW-1:0] red_out;
	logic [OW-1:0] green_out;
	logic [OW-1:0] blue_out;
	logic          was_scaled;

	pixel_req_t  pending_pixels[$];
	pixel_out_t  expected_pixels[$];
	int unsigned sender_idle_pct = 0;
	int unsigned mismatches = 0;

	rgb_clamp_normalize_quantize #(
		.FRAC_BITS(FRAC_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.red_in(red_in),
		.green_in(green_in),
		.blue_in(blue_in),
		.done(done),
		.red_out(red_out),
		.green_out(green_out),
		.blue_out(blue_out),
		.was_scaled(was_scaled)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic pixel_out_t clamp_quantize(input logic [CW-1:0] r, g, b);
		logic [63:0] c [NCOMP];
		logic [63:0] sumsq;
		logic [63:0] num2;
		logic [63:0] trial;
		logic [63:0] k;
		pixel_out_t  res;
		c[0] = 64'(r);
		c[1] = 64'(g);
		c[2] = 64'(b);
		sumsq = c[0] * c[0] + c[1] * c[1] + c[2] * c[2];
		res.scaled = sumsq > (64'd1 << (2 * FRAC_BITS));
		for (int i = 0; i < NCOMP; i++) begin
			if (res.scaled) begin
				num2 = (64'd255 * c[i]) * (64'd255 * c[i]);
				k = '0;
				for (int bitpos = OW - 1; bitpos >= 0; bitpos--) begin
					trial = k | (64'd1 << bitpos);
					if (trial * trial * sumsq <= num2)
						k = trial;
				end
			end else begin
				k = (64'd255 * c[i]) >> FRAC_BITS;
				if (k > 64'd255)
					k = 64'd255;
			end
			res.comp[i] = k[OW-1:0];
		end
		return res;
	endfunction

	task automatic add_pixel(input logic [CW-1:0] r, g, b);
		pixel_req_t req;
		req.drain = 1'b0;
		req.idle_pct = sender_idle_pct;
		req.red = r;
		req.green = g;
		req.blue = b;
		pending_pixels.push_back(req);
	endtask

	task automatic add_drain();
		pixel_req_t req;
		req.drain = 1'b1;
		req.idle_pct = 0;
		req.red = '0;
		req.green = '0;
		req.blue = '0;
		pending_pixels.push_back(req);
	endtask

	function automatic logic [CW-1:0] rand_comp(input int unsigned mode);
		logic [CW-1:0] v;
		case (mode)
			0: v = CW'($urandom_range(2364));
			1: v = CW'($urandom_range(4200));
			2: v = CW'($urandom_range(4096 + 64, 4096 - 64));
			default: v = CW'($urandom);
		endcase
		return v;
	endfunction

	// Driver: hold an offered transaction until accepted, record its prediction at acceptance.
	always @(posedge clk) begin
		pixel_req_t req;
		bit         go;
		if (arst_n) begin
			if (start && !busy)
				expected_pixels.push_back(clamp_quantize(red_in, green_in, blue_in));
			if (!(start && busy)) begin
				go = 1'b0;
				if (pending_pixels.size() > 0) begin
					if (pending_pixels[0].drain) begin
						if (expected_pixels.size() == 0)
							void'(pending_pixels.pop_front());
					end else if ($urandom_range(99) >= pending_pixels[0].idle_pct) begin
						req = pending_pixels.pop_front();
						red_in <= req.red;
						green_in <= req.green;
						blue_in <= req.blue;
						go = 1'b1;
					end
				end
				start <= go;
			end
		end
	end

	// Monitor: compare each result with the oldest prediction.
	always @(posedge clk) begin
		pixel_out_t exp_px;
		if (arst_n && done) begin
			if (expected_pixels.size() == 0) begin
				$display("%0t: unexpected result r=%0d g=%0d b=%0d s=%0d", $time,
					red_out, green_out, blue_out, was_scaled);
				mismatches++;
			end else begin
				exp_px = expected_pixels.pop_front();
				if (red_out !== exp_px.comp[0] || green_out !== exp_px.comp[1] ||
						blue_out !== exp_px.comp[2] || was_scaled !== exp_px.scaled) begin
					$display("%0t: expected r=%0d g=%0d b=%0d s=%0d, got r=%0d g=%0d b=%0d s=%0d",
						$time, exp_px.comp[0], exp_px.comp[1], exp_px.comp[2], exp_px.scaled,
						red_out, green_out, blue_out, was_scaled);
					mismatches++;
				end
			end
		end
	end

	initial begin
		int unsigned phase_idle [4];
		int unsigned mode;

		phase_idle = '{0, 76, 0, 8};

		// Directed corners: zero, full scale, unit axes, either side of length one.
		add_pixel(16'd0, 16'd0, 16'd0);
		add_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
		add_pixel(16'd4096, 16'd0, 16'd0);
		add_pixel(16'd0, 16'd4096, 16'd0);
		add_pixel(16'd0, 16'd0, 16'd4096);
		add_pixel(16'd4095, 16'd0, 16'd0);
		add_pixel(16'd4097, 16'd0, 16'd0);
		add_pixel(16'd4096, 16'd1, 16'd0);
		add_pixel(16'd2896, 16'd2896, 16'd0);
		add_pixel(16'd2897, 16'd2896, 16'd0);
		add_pixel(16'd2364, 16'd2364, 16'd2364);
		add_pixel(16'd2365, 16'd2365, 16'd2365);
		add_pixel(16'hFFFF, 16'd0, 16'd0);
		add_pixel(16'd0, 16'hFFFF, 16'd1);
		add_pixel(16'd1, 16'd1, 16'd1);
		add_pixel(16'h5555, 16'hAAAA, 16'h5555);
		add_pixel(16'hAAAA, 16'h5555, 16'hAAAA);
		add_pixel(16'h8000, 16'h4000, 16'h2000);
		add_pixel(16'd1000, 16'd2000, 16'd3000);
		add_drain();

		for (int p = 0; p < 4; p++) begin
			sender_idle_pct = phase_idle[p];
			for (int n = 0; n < 125; n++) begin
				mode = $urandom_range(3);
				add_pixel(rand_comp(mode), rand_comp($urandom_range(3) == 0 ? 3 : mode),
					rand_comp(mode));
			end
			add_drain();
		end

		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		do
			@(negedge clk);
		while (pending_pixels.size() > 0 || start);
		do
			@(negedge clk);
		while (expected_pixels.size() > 0);
		repeat (2 * LATENCY) @(negedge clk);

		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#200000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
